### hdl/pidaw_pkg.sv
// Package for the PID controller with anti-windup: widths, codes, beat and
// state types, and the fixed-point helper functions. No dependencies.
package pidaw_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int GAIN_FRAC_BITS = 16;
   localparam int GAIN_W         = 24;
   localparam int FIX_W          = 32;
   localparam int TIME_W         = 32;
   localparam int PERIOD_W       = 16;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET_MS = PERIOD_W'(1000);

   // gain (unsigned, one sign bit added) times a difference of two samples
   localparam int DIFF_W = SAMPLE_WIDTH + 1;
   localparam int PROD_W = GAIN_W + SAMPLE_WIDTH + 2;
   localparam int SHR    = (GAIN_FRAC_BITS > 16) ? GAIN_FRAC_BITS - 16 : 0;
   localparam int SHL    = (GAIN_FRAC_BITS < 16) ? 16 - GAIN_FRAC_BITS : 0;
   localparam int TERM_W = PROD_W + SHL;
   localparam int SUM_W  = TERM_W + 2;
   localparam longint TERM_SAT = 64'sd4503599627370496;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_AUTO   = 2'd1;
   localparam logic [1:0] OP_MANUAL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_MAX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE    = 3'd6;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [FIX_W-1:0]        fix_type;
   typedef logic signed [DIFF_W-1:0]       diff_type;
   typedef logic signed [PROD_W-1:0]       prod_type;
   typedef logic signed [TERM_W-1:0]       term_type;
   typedef logic signed [SUM_W-1:0]        sum_type;

   typedef struct packed {
      logic [1:0]        opcode;
      sample_type        setpoint;
      sample_type        measurement;
      logic [TIME_W-1:0] time_ms;
   } item_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   prop_gain;
      logic [GAIN_W-1:0]   integ_gain;
      logic [GAIN_W-1:0]   deriv_gain;
      fix_type             output_min;
      fix_type             output_max;
      logic [PERIOD_W-1:0] sample_period_ms;
      logic                reverse_action;
      logic                reclamp;   // pulse the cycle after a limit write
   } cfg_type;

   typedef struct packed {
      fix_type           held_output;
      fix_type           integral_sum;
      sample_type        previous_measurement;
      logic [TIME_W-1:0] last_update_time;
      logic              automatic_on;
   } state_type;

   // Crossed limits: above max wins over below min.
   function automatic fix_type limit(sum_type v, fix_type lo, fix_type hi);
      fix_type r;
      if (v > sum_type'(hi)) begin
         r = hi;
      end else if (v < sum_type'(lo)) begin
         r = lo;
      end else begin
         r = fix_type'(v);
      end
      return r;
   endfunction

   // gain * x, optionally negated, rescaled to Q26.16
   function automatic term_type gain_term(logic [GAIN_W-1:0] gain, diff_type x,
                                          logic reverse);
      logic signed [GAIN_W:0] g;
      prod_type p;
      longint pl;
      term_type r;
      g = {1'b0, gain};
      p = prod_type'(g) * prod_type'(x);
      if (reverse) begin
         p = -p;
      end
      pl = longint'(p);
      if (GAIN_FRAC_BITS > 16) begin
         r = term_type'(p >>> SHR);
      end else if (GAIN_FRAC_BITS < 16) begin
         if (pl > TERM_SAT) begin
            pl = TERM_SAT;
         end
         if (pl < -TERM_SAT) begin
            pl = -TERM_SAT;
         end
         r = term_type'(pl) <<< SHL;
      end else begin
         r = term_type'(p);
      end
      return r;
   endfunction

endpackage

### hdl/pidaw_if.sv
// Channel interfaces of the PID controller: sample request, drive response
// and register write. Depends on pidaw_pkg.
interface pidaw_req_if;
   import pidaw_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          opcode;
   sample_type          setpoint;
   sample_type          measurement;
   logic [TIME_W-1:0]   time_ms;
   modport source (output valid, opcode, setpoint, measurement, time_ms, input ready);
   modport sink   (input valid, opcode, setpoint, measurement, time_ms, output ready);
endinterface

interface pidaw_rsp_if;
   import pidaw_pkg::*;
   logic    valid;
   logic    ready;
   fix_type drive;
   logic    updated;
   modport source (output valid, drive, updated, input ready);
   modport sink   (input valid, drive, updated, output ready);
endinterface

interface pidaw_csr_if;
   import pidaw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hdl/pidaw_csr.sv
// Configuration register file of the PID controller; flags limit writes so
// the state can be reclamped. Depends on pidaw_pkg and pidaw_csr_if.
module pidaw_csr (
   input  logic               clock,
   input  logic               reset,
   pidaw_csr_if.sink          csr_bus,
   output pidaw_pkg::cfg_type cfg
);
   import pidaw_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    write;

   assign csr_bus.ready = 1'b1;
   assign write = csr_bus.valid;

   always_comb begin
      cfg_in = cfg_ff;
      cfg_in.reclamp = 1'b0;
      if (write) begin
         case (csr_bus.index)
            REG_PROP_GAIN:  cfg_in.prop_gain  = csr_bus.data[GAIN_W-1:0];
            REG_INTEG_GAIN: cfg_in.integ_gain = csr_bus.data[GAIN_W-1:0];
            REG_DERIV_GAIN: cfg_in.deriv_gain = csr_bus.data[GAIN_W-1:0];
            REG_OUTPUT_MIN: begin
               cfg_in.output_min = fix_type'(csr_bus.data);
               cfg_in.reclamp    = 1'b1;
            end
            REG_OUTPUT_MAX: begin
               cfg_in.output_max = fix_type'(csr_bus.data);
               cfg_in.reclamp    = 1'b1;
            end
            REG_PERIOD:     cfg_in.sample_period_ms = csr_bus.data[PERIOD_W-1:0];
            REG_REVERSE:    cfg_in.reverse_action   = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{prop_gain:        '0,
                     integ_gain:       '0,
                     deriv_gain:       '0,
                     output_min:       '0,
                     output_max:       '0,
                     sample_period_ms: PERIOD_RESET_MS,
                     reverse_action:   1'b0,
                     reclamp:          1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/pidaw_calc.sv
// One controller step: mode switches, period check, PID update with clamped
// integral and drive. Pure combinational. Depends on pidaw_pkg.
module pidaw_calc (
   input  pidaw_pkg::item_type  item,
   input  pidaw_pkg::state_type state,
   input  pidaw_pkg::cfg_type   cfg,
   output pidaw_pkg::state_type state_next,
   output logic                 updated
);
   import pidaw_pkg::*;

   diff_type          err;
   diff_type          dmeas;
   term_type          p_term;
   term_type          i_term;
   term_type          d_term;
   fix_type           integ_new;
   sum_type           drive_sum;
   logic [TIME_W-1:0] elapsed;
   logic              due;

   assign err     = diff_type'(item.setpoint) - diff_type'(item.measurement);
   assign dmeas   = diff_type'(item.measurement) - diff_type'(state.previous_measurement);
   assign elapsed = item.time_ms - state.last_update_time;
   assign due     = elapsed >= TIME_W'(cfg.sample_period_ms);

   assign p_term = gain_term(cfg.prop_gain, err, cfg.reverse_action);
   assign i_term = gain_term(cfg.integ_gain, err, cfg.reverse_action);
   assign d_term = gain_term(cfg.deriv_gain, dmeas, cfg.reverse_action);

   assign integ_new = limit(sum_type'(state.integral_sum) + sum_type'(i_term),
                            cfg.output_min, cfg.output_max);
   assign drive_sum = sum_type'(p_term) + sum_type'(integ_new) - sum_type'(d_term);

   always_comb begin
      state_next = state;
      updated    = 1'b0;
      case (item.opcode)
         OP_AUTO: begin
            // bumpless transfer only on a manual-to-automatic change
            if (!state.automatic_on) begin
               state_next.previous_measurement = item.measurement;
               state_next.integral_sum = limit(sum_type'(state.held_output),
                                               cfg.output_min, cfg.output_max);
            end
            state_next.automatic_on = 1'b1;
         end
         OP_MANUAL: state_next.automatic_on = 1'b0;
         OP_SAMPLE: begin
            if (state.automatic_on && due) begin
               state_next.integral_sum         = integ_new;
               state_next.held_output          = limit(drive_sum, cfg.output_min,
                                                       cfg.output_max);
               state_next.previous_measurement = item.measurement;
               state_next.last_update_time     = item.time_ms;
               updated                         = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

### hdl/pid_controller_antiwindup.sv
// Top level of the PID controller with anti-windup: input register, state,
// result register and handshake. Depends on pidaw_pkg, the interfaces,
// pidaw_csr and pidaw_calc.
//
//   channel   dir   beat contents
//   req_bus   in    opcode, setpoint, measurement, time_ms
//   rsp_bus   out   drive, updated (one beat per request beat)
//   csr_bus   in    index, data (always ready)
//
// A request beat is registered in the input register, then processed once
// the result register is free or being taken; its response is registered
// in the result register. One beat per cycle sustained while rsp_bus.ready
// is high, set by the combinational state update through the gain
// multipliers and clamps. A stalled response holds one item in the result
// register and one in the input register before req_bus.ready drops. Reset
// is synchronous; a limit write is registered, then reclamps the state.
module pid_controller_antiwindup (
   input logic        clock,
   input logic        reset,
   pidaw_req_if.sink  req_bus,
   pidaw_rsp_if.source rsp_bus,
   pidaw_csr_if.sink  csr_bus
);
   import pidaw_pkg::*;

   cfg_type   cfg;
   item_type  item_ff, item_in;
   logic      in_valid_ff, in_valid_in;
   state_type state_ff, state_in;
   state_type state_cur;
   state_type calc_state;
   logic      calc_updated;
   logic      out_valid_ff, out_valid_in;
   fix_type   drive_ff, drive_in;
   logic      updated_ff, updated_in;
   logic      advance;
   logic      req_take;

   pidaw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   pidaw_calc u_calc (
      .item       (item_ff),
      .state      (state_cur),
      .cfg        (cfg),
      .state_next (calc_state),
      .updated    (calc_updated)
   );

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         item_in.opcode      = req_bus.opcode;
         item_in.setpoint    = req_bus.setpoint;
         item_in.measurement = req_bus.measurement;
         item_in.time_ms     = req_bus.time_ms;
         in_valid_in         = 1'b1;
      end
   end

   // a limit write reclamps the state before any item sees it
   always_comb begin
      state_cur = state_ff;
      if (cfg.reclamp) begin
         state_cur.held_output  = limit(sum_type'(state_ff.held_output),
                                        cfg.output_min, cfg.output_max);
         state_cur.integral_sum = limit(sum_type'(state_ff.integral_sum),
                                        cfg.output_min, cfg.output_max);
      end
   end

   always_comb begin
      state_in = state_cur;
      if (advance) begin
         state_in = calc_state;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      drive_in     = drive_ff;
      updated_in   = updated_ff;
      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         drive_in     = calc_state.held_output;
         updated_in   = calc_updated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      drive_ff   <= drive_in;
      updated_ff <= updated_in;
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.drive   = drive_ff;
   assign rsp_bus.updated = updated_ff;

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed beat did not reach the result register");

   a_manual_no_update: assert property (@(posedge clock) disable iff (reset)
      advance && !state_ff.automatic_on |=> !updated_ff)
      else $error("update reported in manual mode");

   a_update_stamps_time: assert property (@(posedge clock) disable iff (reset)
      advance && calc_updated |=> state_ff.last_update_time == $past(item_ff.time_ms))
      else $error("update did not record its timestamp");

   a_stalled_item_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(item_ff))
      else $error("waiting input item was lost or changed");

   a_drive_is_held: assert property (@(posedge clock) disable iff (reset)
      advance |=> drive_ff == state_ff.held_output)
      else $error("result drive differs from held output");

endmodule
